// ===== src/thermistor_temperature_averager_defines.svh =====
// Assertion helpers for the thermistor averager
`ifndef THERMISTOR_TEMPERATURE_AVERAGER_DEFINES_SVH
`define THERMISTOR_TEMPERATURE_AVERAGER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define TTA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tta check failed");

// Next-cycle implication, checked out of reset
`define TTA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tta check failed");

`endif

// ===== src/tta_pkg.sv =====
`default_nettype none
package tta_pkg;

  // Defaults for the top-level parameters
  localparam int SampleBitsDef = 10;
  localparam int MaxSamplesDef = 16;

  // Stream and config port widths
  localparam int InDataW  = 16;
  localparam int OutDataW = 16;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 20;

  // Register field widths
  localparam int RsW = 20;
  localparam int BW  = 14;
  localparam int R0W = 20;
  localparam int T0W = 16;
  localparam int NW  = 5;
  localparam int TempW  = 12;
  localparam int FaultW = 2;

  // Shared divider and accumulator widths
  localparam int DivW = 44;
  localparam int AccW = 48;

  // Constants of the conversion
  localparam int Ln2Q16     = 45426;
  localparam int ZeroCMilli = 273150;
  localparam int TempLow    = -550;
  localparam int TempHigh   = 1500;
  localparam logic [DivW-1:0] InvT0Num = DivW'(100) << 32;
  localparam logic [DivW-1:0] InvTNum  = DivW'(1000) << 32;

  // Divide by 100 as multiply by ceil(2^24/100), exact below the clamp points
  localparam int Div100Mul   = 167773;
  localparam int Div100Shift = 24;
  localparam int MilliHigh   = (TempHigh + 1) * 100;
  localparam int MilliLow    = (1 - TempLow) * 100;

  // Reset values of the registers
  localparam logic [RsW-1:0] RsRst = RsW'(4500);
  localparam logic [BW-1:0]  BRst  = BW'(3950);
  localparam logic [R0W-1:0] R0Rst = R0W'(100000);
  localparam logic [T0W-1:0] T0Rst = T0W'(29815);
  localparam logic [NW-1:0]  NRst  = NW'(10);

  typedef enum logic [CfgIdxW-1:0] {
    REG_SERIES  = 3'd0,
    REG_BETA    = 3'd1,
    REG_NOMINAL = 3'd2,
    REG_T0      = 3'd3,
    REG_COUNT   = 3'd4
  } reg_idx_e;

  typedef enum logic [FaultW-1:0] {
    FAULT_NONE = 2'd0,
    FAULT_ZERO = 2'd1,
    FAULT_FULL = 2'd2
  } fault_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_NORM,
    ST_SQR,
    ST_SCALE,
    ST_DIV,
    ST_POST,
    ST_OUT
  } state_e;

  typedef enum logic [2:0] {
    PH_LOGA,
    PH_LOGB,
    PH_DIVB,
    PH_DIVT0,
    PH_DIVT,
    PH_DIV100
  } phase_e;

endpackage
`default_nettype wire

// ===== src/thermistor_temperature_averager.sv =====
// An item that does not close an average is added to the running sum and count.
// An item that closes an average holds input off while its conversion runs, longer
// when the bit-serial normalize shifts more; the conversion runs the normalize
// and squaring steps of the log unit and the bit-serial divider.
// Input is not ready while a conversion runs; a full result register adds stall cycles.
// Reset (rst_ni low, async) clears sum, count, state and restores register defaults.
`default_nettype none
`include "thermistor_temperature_averager_defines.svh"
module thermistor_temperature_averager #(
  parameter int SAMPLE_BITS = tta_pkg::SampleBitsDef,
  parameter int MAX_SAMPLES = tta_pkg::MaxSamplesDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // [9:0] adc_sample, rest zero
  input  wire [tta_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // [11:0] temp_tenths_c, [13:12] fault, rest zero
  output logic [tta_pkg::OutDataW-1:0] m_axis_tdata,
  input  wire                          cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire [tta_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire [tta_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int SumW = SAMPLE_BITS + $clog2(MAX_SAMPLES + 1);
  localparam int CntW = $clog2(MAX_SAMPLES + 1);
  localparam int XRaw = tta_pkg::RsW + SumW;
  localparam int XW   = (XRaw > 32) ? XRaw : 32;
  localparam int EW   = $clog2(XW);
  localparam int LgW  = EW + 17;
  localparam int DW   = tta_pkg::DivW;
  localparam int AW   = tta_pkg::AccW;
  localparam int DcW  = $clog2(DW);

  // Config registers
  logic [tta_pkg::RsW-1:0] rs_q;
  logic [tta_pkg::BW-1:0]  b_q;
  logic [tta_pkg::R0W-1:0] r0_q;
  logic [tta_pkg::T0W-1:0] t0_q;
  logic [tta_pkg::NW-1:0]  n_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q <= tta_pkg::RsRst;
      b_q  <= tta_pkg::BRst;
      r0_q <= tta_pkg::R0Rst;
      t0_q <= tta_pkg::T0Rst;
      n_q  <= tta_pkg::NRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        tta_pkg::REG_SERIES:  rs_q <= cfg_data_i[tta_pkg::RsW-1:0];
        tta_pkg::REG_BETA:    b_q  <= cfg_data_i[tta_pkg::BW-1:0];
        tta_pkg::REG_NOMINAL: r0_q <= cfg_data_i[tta_pkg::R0W-1:0];
        tta_pkg::REG_T0:      t0_q <= cfg_data_i[tta_pkg::T0W-1:0];
        tta_pkg::REG_COUNT:   n_q  <= cfg_data_i[tta_pkg::NW-1:0];
        default: ;
      endcase
    end
  end

  // Zero registers act as one; count clamped to 1..MAX_SAMPLES
  logic [tta_pkg::RsW-1:0] rs_eff;
  logic [tta_pkg::BW-1:0]  b_eff;
  logic [tta_pkg::R0W-1:0] r0_eff;
  logic [tta_pkg::T0W-1:0] t0_eff;
  logic [CntW-1:0]         n_eff;

  always_comb begin
    rs_eff = (rs_q == '0) ? tta_pkg::RsW'(1) : rs_q;
    b_eff  = (b_q == '0)  ? tta_pkg::BW'(1)  : b_q;
    r0_eff = (r0_q == '0) ? tta_pkg::R0W'(1) : r0_q;
    t0_eff = (t0_q == '0) ? tta_pkg::T0W'(1) : t0_q;
    if (n_q == '0) begin
      n_eff = CntW'(1);
    end else if (32'(n_q) > MAX_SAMPLES) begin
      n_eff = CntW'(MAX_SAMPLES);
    end else begin
      n_eff = CntW'(n_q);
    end
  end

  // Sequencer and datapath registers
  tta_pkg::state_e state_q, state_d;
  tta_pkg::phase_e phase_q, phase_d;
  logic [SumW-1:0]   sum_q, sum_d, cap_q, cap_d;
  logic [CntW-1:0]   cnt_q, cnt_d, ncap_q, ncap_d;
  logic [XW-1:0]     x_q, x_d;
  logic [EW-1:0]     e_q, e_d;
  logic [31:0]       m_q, m_d;
  logic [3:0]        bit_q, bit_d;
  logic [15:0]       frac_q, frac_d;
  logic signed [LgW-1:0] lga_q, lga_d;
  logic signed [AW-1:0]  acc_q, acc_d;
  logic [DW-1:0]     dvd_q, dvd_d, dvs_q, dvs_d;
  logic [DW:0]       rem_q, rem_d;
  logic [DcW-1:0]    dcnt_q, dcnt_d;
  logic              neg_q, neg_d;
  logic [tta_pkg::TempW-1:0]  res_temp_q, res_temp_d, out_temp_q, out_temp_d;
  logic [tta_pkg::FaultW-1:0] res_fault_q, res_fault_d, out_fault_q, out_fault_d;
  logic              out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tta_pkg::ST_IDLE;
      phase_q     <= tta_pkg::PH_LOGA;
      sum_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cap_q       <= cap_d;
    ncap_q      <= ncap_d;
    x_q         <= x_d;
    e_q         <= e_d;
    m_q         <= m_d;
    bit_q       <= bit_d;
    frac_q      <= frac_d;
    lga_q       <= lga_d;
    acc_q       <= acc_d;
    dvd_q       <= dvd_d;
    dvs_q       <= dvs_d;
    rem_q       <= rem_d;
    dcnt_q      <= dcnt_d;
    neg_q       <= neg_d;
    res_temp_q  <= res_temp_d;
    res_fault_q <= res_fault_d;
    out_temp_q  <= out_temp_d;
    out_fault_q <= out_fault_d;
  end

  assign s_axis_tready = (state_q == tta_pkg::ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = tta_pkg::OutDataW'({out_fault_q, out_temp_q});

  // Shared arithmetic: squarer, divider step, signed quotient, divide by 100
  logic [63:0]          sq;
  logic [32:0]          sq_sh;
  logic [DW:0]          rem_sh;
  logic                 rem_ge;
  logic signed [AW-1:0] quo_s;
  logic signed [LgW-1:0] lg_r;
  logic signed [AW-1:0] tmp_s;
  logic [SumW:0]        cnt_sum;
  logic [CntW:0]        cnt_new;
  logic [SumW-1:0]      full;
  logic [35:0]          d100_prod;
  logic [10:0]          d100_quo;

  always_comb begin
    sq     = {32'd0, m_q} * {32'd0, m_q};
    sq_sh  = sq[63:31];
    rem_sh = {rem_q[DW-1:0], dvd_q[DW-1]};
    rem_ge = rem_sh >= {1'b0, dvs_q};
    quo_s  = neg_q ? -$signed(AW'(dvd_q)) : $signed(AW'(dvd_q));
    lg_r   = $signed({1'b0, e_q, frac_q});
    full   = SumW'(ncap_q) << SAMPLE_BITS;
    // magnitude below the clamp points fits 18 bits
    d100_prod = 36'(dvd_q[17:0]) * 36'(tta_pkg::Div100Mul);
    d100_quo  = d100_prod[tta_pkg::Div100Shift +: 11];
  end

  // Sequencer: next state and datapath updates
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    sum_d       = sum_q;
    cnt_d       = cnt_q;
    cap_d       = cap_q;
    ncap_d      = ncap_q;
    x_d         = x_q;
    e_d         = e_q;
    m_d         = m_q;
    bit_d       = bit_q;
    frac_d      = frac_q;
    lga_d       = lga_q;
    acc_d       = acc_q;
    dvd_d       = dvd_q;
    dvs_d       = dvs_q;
    rem_d       = rem_q;
    dcnt_d      = dcnt_q;
    neg_d       = neg_q;
    res_temp_d  = res_temp_q;
    res_fault_d = res_fault_q;
    out_temp_d  = out_temp_q;
    out_fault_d = out_fault_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    tmp_s       = '0;
    cnt_sum     = '0;
    cnt_new     = '0;

    case (state_q)
      tta_pkg::ST_IDLE: begin
        if (s_axis_tvalid) begin
          cnt_sum = {1'b0, sum_q} + (SumW + 1)'(s_axis_tdata[SAMPLE_BITS-1:0]);
          cnt_new = {1'b0, cnt_q} + (CntW + 1)'(1);
          if (cnt_new >= {1'b0, n_eff}) begin
            sum_d  = '0;
            cnt_d  = '0;
            cap_d  = cnt_sum[SumW-1:0];
            ncap_d = n_eff;
            res_temp_d = '0;
            if (cnt_sum[SumW-1:0] == '0) begin
              res_fault_d = tta_pkg::FAULT_ZERO;
              state_d     = tta_pkg::ST_OUT;
            end else if (cnt_sum[SumW-1:0] >= (SumW'(n_eff) << SAMPLE_BITS)) begin
              res_fault_d = tta_pkg::FAULT_FULL;
              state_d     = tta_pkg::ST_OUT;
            end else begin
              res_fault_d = tta_pkg::FAULT_NONE;
              phase_d     = tta_pkg::PH_LOGA;
              state_d     = tta_pkg::ST_MUL;
            end
          end else begin
            sum_d = cnt_sum[SumW-1:0];
            cnt_d = cnt_new[CntW-1:0];
          end
        end
      end

      // Rs * (N*FS - sum)
      tta_pkg::ST_MUL: begin
        x_d     = XW'(rs_eff) * XW'(full - cap_q);
        e_d     = EW'(XW - 1);
        state_d = tta_pkg::ST_NORM;
      end

      // One-bit normalize until the top bit is set
      tta_pkg::ST_NORM: begin
        if (x_q[XW-1]) begin
          m_d     = x_q[XW-1 -: 32];
          bit_d   = 4'd15;
          frac_d  = '0;
          state_d = tta_pkg::ST_SQR;
        end else begin
          x_d = x_q << 1;
          e_d = e_q - EW'(1);
        end
      end

      // Square the mantissa, one fraction bit per cycle
      tta_pkg::ST_SQR: begin
        if (sq_sh[32]) begin
          m_d = sq_sh[32:1];
          frac_d[bit_q] = 1'b1;
        end else begin
          m_d = sq_sh[31:0];
        end
        bit_d = bit_q - 4'd1;
        if (bit_q == 4'd0) begin
          state_d = tta_pkg::ST_POST;
        end
      end

      // dl * ln2, then divide by beta
      tta_pkg::ST_SCALE: begin
        tmp_s   = acc_q * AW'(tta_pkg::Ln2Q16);
        neg_d   = tmp_s < 0;
        dvd_d   = DW'(tmp_s < 0 ? -tmp_s : tmp_s);
        dvs_d   = DW'(b_eff);
        rem_d   = '0;
        dcnt_d  = '0;
        phase_d = tta_pkg::PH_DIVB;
        state_d = tta_pkg::ST_DIV;
      end

      // Restoring divider, one quotient bit per cycle
      tta_pkg::ST_DIV: begin
        rem_d  = rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
        dvd_d  = {dvd_q[DW-2:0], rem_ge};
        dcnt_d = dcnt_q + DcW'(1);
        if (dcnt_q == DcW'(DW - 1)) begin
          state_d = tta_pkg::ST_POST;
        end
      end

      tta_pkg::ST_POST: begin
        rem_d  = '0;
        dcnt_d = '0;
        case (phase_q)
          tta_pkg::PH_LOGA: begin
            lga_d   = lg_r;
            x_d     = XW'(cap_q) * XW'(r0_eff);
            e_d     = EW'(XW - 1);
            phase_d = tta_pkg::PH_LOGB;
            state_d = tta_pkg::ST_NORM;
          end
          tta_pkg::PH_LOGB: begin
            acc_d   = AW'(lga_q - lg_r);
            state_d = tta_pkg::ST_SCALE;
          end
          tta_pkg::PH_DIVB: begin
            acc_d   = quo_s;
            neg_d   = 1'b0;
            dvd_d   = tta_pkg::InvT0Num;
            dvs_d   = DW'(t0_eff);
            phase_d = tta_pkg::PH_DIVT0;
            state_d = tta_pkg::ST_DIV;
          end
          tta_pkg::PH_DIVT0: begin
            tmp_s = quo_s + acc_q;
            if (tmp_s <= 0) begin
              res_temp_d = tta_pkg::TempW'(tta_pkg::TempHigh);
              state_d    = tta_pkg::ST_OUT;
            end else begin
              neg_d   = 1'b0;
              dvd_d   = tta_pkg::InvTNum;
              dvs_d   = DW'(tmp_s);
              phase_d = tta_pkg::PH_DIVT;
              state_d = tta_pkg::ST_DIV;
            end
          end
          // Millidegrees as sign and magnitude for the divide by 100
          tta_pkg::PH_DIVT: begin
            tmp_s   = quo_s - AW'(tta_pkg::ZeroCMilli);
            neg_d   = tmp_s < 0;
            dvd_d   = DW'(tmp_s < 0 ? -tmp_s : tmp_s);
            phase_d = tta_pkg::PH_DIV100;
          end
          // Clamp far values, else reciprocal multiply truncates toward zero
          tta_pkg::PH_DIV100: begin
            if (neg_q) begin
              if (dvd_q >= DW'(tta_pkg::MilliLow)) begin
                res_temp_d = tta_pkg::TempW'(tta_pkg::TempLow);
              end else begin
                res_temp_d = -tta_pkg::TempW'(d100_quo);
              end
            end else if (dvd_q >= DW'(tta_pkg::MilliHigh)) begin
              res_temp_d = tta_pkg::TempW'(tta_pkg::TempHigh);
            end else begin
              res_temp_d = tta_pkg::TempW'(d100_quo);
            end
            state_d = tta_pkg::ST_OUT;
          end
          default: state_d = tta_pkg::ST_IDLE;
        endcase
      end

      // Hand the result to the output register when it is free
      tta_pkg::ST_OUT: begin
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_temp_d  = res_temp_q;
          out_fault_d = res_fault_q;
          state_d     = tta_pkg::ST_IDLE;
        end
      end

      default: state_d = tta_pkg::ST_IDLE;
    endcase
  end

  // Checks
  `TTA_ASSERT_NOW(a_busy_not_ready, state_q != tta_pkg::ST_IDLE, !s_axis_tready)
  `TTA_ASSERT_NOW(a_fault_zero_temp, m_axis_tvalid && (m_axis_tdata[13:12] != tta_pkg::FAULT_NONE),
                  m_axis_tdata[11:0] == 12'd0)
  `TTA_ASSERT_NOW(a_temp_range, m_axis_tvalid,
                  ($signed(m_axis_tdata[11:0]) >= -12'sd550) &&
                  ($signed(m_axis_tdata[11:0]) <= 12'sd1500))
  `TTA_ASSERT_NOW(a_norm_nonzero, state_q == tta_pkg::ST_NORM, x_q != '0)
  `TTA_ASSERT_NXT(a_sqr_done, (state_q == tta_pkg::ST_SQR) && (bit_q == 4'd0),
                  state_q == tta_pkg::ST_POST)

endmodule
`default_nettype wire
